// ===== rtl/bba_pkg.sv =====
package bba_pkg;

    localparam int MIN_BLOCK_LOG2 = 6;
    localparam int MAX_POOL_LOG2  = 20;
    localparam int HEADER_BYTES   = 32;

    localparam int UNIT_W     = MAX_POOL_LOG2 - MIN_BLOCK_LOG2;
    localparam int UNIT_COUNT = 1 << UNIT_W;
    localparam int LINK_W     = UNIT_W + 1;
    localparam int LEVELS     = MAX_POOL_LOG2 + 1;
    localparam int ORD_W      = 5;
    localparam int ADDR_W     = 20;
    localparam int SIZE_W     = 32;
    localparam int NEED_W     = SIZE_W + 1;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(UNIT_COUNT);

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [ORD_W-1:0]  ord_t;

    typedef enum logic [1:0] {
        TAG_NONE = 2'd0,
        TAG_FREE = 2'd1,
        TAG_USED = 2'd2,
        TAG_RSVD = 2'd3
    } tag_t;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_NULL = 2'd2;

    typedef struct packed {
        tag_t tag;
        ord_t order;
    } meta_t;

    typedef struct packed {
        unit_t meta_raddr;
        unit_t link_raddr;
        logic  meta_we;
        unit_t meta_waddr;
        meta_t meta_wdata;
        logic  next_we;
        unit_t next_waddr;
        link_t next_wdata;
        logic  prev_we;
        unit_t prev_waddr;
        link_t prev_wdata;
    } store_ctl_t;

    typedef struct packed {
        meta_t meta;
        link_t next;
        link_t prev;
    } store_rd_t;

endpackage

// ===== rtl/bba_store.sv =====
module bba_store
    import bba_pkg::*;
(
    input  logic       clk,
    input  store_ctl_t ctl,
    output store_rd_t  rd
);

    meta_t meta_mem [UNIT_COUNT];
    link_t next_mem [UNIT_COUNT];
    link_t prev_mem [UNIT_COUNT];

    always_ff @(posedge clk)
    begin
        if (ctl.meta_we)
        begin
            meta_mem[ctl.meta_waddr] <= ctl.meta_wdata;
        end
        if (ctl.next_we)
        begin
            next_mem[ctl.next_waddr] <= ctl.next_wdata;
        end
        if (ctl.prev_we)
        begin
            prev_mem[ctl.prev_waddr] <= ctl.prev_wdata;
        end
        rd.meta <= meta_mem[ctl.meta_raddr];
        rd.next <= next_mem[ctl.link_raddr];
        rd.prev <= prev_mem[ctl.link_raddr];
    end

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// From accept to result strobe, an allocate steps through the size and free-list
// searches, one order per step, then splits once per order it steps down; a free
// checks the address, then merges with each free buddy; a rejected item skips both
// walks. A moving reallocate runs both walks back to back. One item at a time: busy
// stays high until the result strobe. Reset or a pool write clears the tag store,
// one unit per cycle, busy high. Each result shows for one cycle on done; no stall.
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [SIZE_W-1:0] request_size,
    input  logic [ADDR_W-1:0] block_address,
    output logic              done,
    output logic [ADDR_W-1:0] address,
    output logic [1:0]        status,
    output logic [ADDR_W-1:0] copy_bytes,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data
);

    typedef enum logic [17:0] {
        S_CLR    = 18'h00001,
        S_FMT    = 18'h00002,
        S_IDLE   = 18'h00004,
        S_DISP   = 18'h00008,
        S_VCHK   = 18'h00010,
        S_AORD   = 18'h00020,
        S_ASRCH  = 18'h00040,
        S_ASPLIT = 18'h00080,
        S_AFIN   = 18'h00100,
        S_FCHK   = 18'h00200,
        S_FTEST  = 18'h00400,
        S_FMRG   = 18'h00800,
        S_FEND   = 18'h01000,
        S_RM1    = 18'h02000,
        S_RM2    = 18'h04000,
        S_PS1    = 18'h08000,
        S_PS2    = 18'h10000,
        S_DONE   = 18'h20000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    ord_t   pool_reg, pool_next;
    unit_t  clr_reg, clr_next;
    link_t  head_reg [LEVELS];

    op_t               op_reg, op_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    unit_t             u_reg, u_next, b_reg, b_next, su_reg, su_next;
    unit_t             old_u_reg, old_u_next;
    ord_t              k_reg, k_next, j_reg, j_next, sk_reg, sk_next;
    ord_t              old_k_reg, old_k_next;
    link_t             h_reg, h_next;
    logic [1:0]        st_reg, st_next;
    logic [ADDR_W-1:0] res_reg, res_next, copy_reg, copy_next;
    logic              done_reg, done_next;
    logic [ADDR_W-1:0] address_reg, address_next, copy_out_reg, copy_out_next;
    logic [1:0]        status_reg, status_next;

    logic       head_we;
    ord_t       head_idx;
    link_t      head_wdata;
    logic       fmt;
    store_ctl_t ctl;
    store_rd_t  rd;

    logic [ADDR_W-1:0] fu_off;
    unit_t             fu_unit;
    logic              fu_ok;
    ord_t              jm1;
    unit_t             split_b, free_b;
    link_t             head_j, head_k;
    logic [NEED_W-1:0] fit_size;

    bba_store u_store (
        .clk (clk),
        .ctl (ctl),
        .rd  (rd)
    );

    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign address    = address_reg;
    assign status     = status_reg;
    assign copy_bytes = copy_out_reg;

    assign fu_off  = addr_reg - ADDR_W'(HEADER_BYTES);
    assign fu_unit = fu_off[ADDR_W-1:MIN_BLOCK_LOG2];
    assign fu_ok   = (addr_reg >= ADDR_W'(HEADER_BYTES))
                     && (fu_off[MIN_BLOCK_LOG2-1:0] == '0)
                     && ((LINK_W'(fu_unit) >> (pool_reg - ORD_W'(MIN_BLOCK_LOG2))) == '0);
    assign jm1      = j_reg - ORD_W'(1);
    assign split_b  = u_reg + (unit_t'(1) << (jm1 - ORD_W'(MIN_BLOCK_LOG2)));
    assign free_b   = u_reg ^ (unit_t'(1) << (k_reg - ORD_W'(MIN_BLOCK_LOG2)));
    assign head_j   = head_reg[j_reg];
    assign head_k   = head_reg[sk_reg];
    assign fit_size = NEED_W'(size_reg) + NEED_W'(HEADER_BYTES);

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        pool_next     = pool_reg;
        clr_next      = clr_reg;
        op_next       = op_reg;
        need_next     = need_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        u_next        = u_reg;
        b_next        = b_reg;
        su_next       = su_reg;
        old_u_next    = old_u_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        sk_next       = sk_reg;
        old_k_next    = old_k_reg;
        h_next        = h_reg;
        st_next       = st_reg;
        res_next      = res_reg;
        copy_next     = copy_reg;
        done_next     = 1'b0;
        address_next  = address_reg;
        status_next   = status_reg;
        copy_out_next = copy_out_reg;
        head_we       = 1'b0;
        head_idx      = sk_reg;
        head_wdata    = LINK_NONE;
        fmt           = 1'b0;
        ctl            = '0;
        ctl.meta_raddr = u_reg;
        ctl.link_raddr = su_reg;

        case (state_reg)
            S_CLR:
            begin
                ctl.meta_we    = 1'b1;
                ctl.meta_waddr = clr_reg;
                ctl.meta_wdata = '{tag: TAG_NONE, order: '0};
                clr_next       = clr_reg + unit_t'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_FMT;
                end
            end
            S_FMT:
            begin
                fmt            = 1'b1;
                ctl.meta_we    = 1'b1;
                ctl.meta_waddr = '0;
                ctl.meta_wdata = '{tag: TAG_FREE, order: pool_reg};
                ctl.next_we    = 1'b1;
                ctl.next_waddr = '0;
                ctl.next_wdata = LINK_NONE;
                ctl.prev_we    = 1'b1;
                ctl.prev_waddr = '0;
                ctl.prev_wdata = LINK_NONE;
                state_next     = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(op);
                    size_next  = request_size;
                    need_next  = NEED_W'(request_size) + NEED_W'(HEADER_BYTES);
                    addr_next  = block_address;
                    st_next    = ST_NULL;
                    res_next   = '0;
                    copy_next  = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                ctl.meta_raddr = fu_unit;
                k_next         = ORD_W'(MIN_BLOCK_LOG2);
                case (op_reg)
                    OP_ALLOC:
                    begin
                        state_next = (size_reg == '0) ? S_DONE : S_AORD;
                    end
                    OP_FREE:
                    begin
                        state_next = (addr_reg == '0) ? S_DONE : S_VCHK;
                    end
                    OP_REALLOC:
                    begin
                        if (addr_reg != '0)
                        begin
                            state_next = S_VCHK;
                        end
                        else
                        begin
                            state_next = (size_reg == '0) ? S_DONE : S_AORD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_VCHK:
            begin
                if (!fu_ok || rd.meta.tag != TAG_USED)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    u_next     = fu_unit;
                    old_u_next = fu_unit;
                    old_k_next = rd.meta.order;
                    if (op_reg == OP_FREE)
                    begin
                        st_next    = ST_OK;
                        k_next     = rd.meta.order;
                        state_next = S_FCHK;
                    end
                    else if (size_reg == '0)
                    begin
                        k_next     = rd.meta.order;
                        state_next = S_FCHK;
                    end
                    else if (fit_size <= (NEED_W'(1) << rd.meta.order))
                    begin
                        res_next   = addr_reg;
                        st_next    = ST_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_AORD;
                    end
                end
            end
            S_AORD:
            begin
                if (k_reg > pool_reg)
                begin
                    st_next    = ST_OOM;
                    state_next = S_DONE;
                end
                else if ((NEED_W'(1) << k_reg) >= need_reg)
                begin
                    j_next     = k_reg;
                    state_next = S_ASRCH;
                end
                else
                begin
                    k_next = k_reg + ORD_W'(1);
                end
            end
            S_ASRCH:
            begin
                if (j_reg > pool_reg)
                begin
                    st_next    = ST_OOM;
                    state_next = S_DONE;
                end
                else if (!head_j[UNIT_W])
                begin
                    u_next     = head_j[UNIT_W-1:0];
                    su_next    = head_j[UNIT_W-1:0];
                    sk_next    = j_reg;
                    ret_next   = S_ASPLIT;
                    state_next = S_RM1;
                end
                else
                begin
                    j_next = j_reg + ORD_W'(1);
                end
            end
            S_ASPLIT:
            begin
                if (j_reg > k_reg)
                begin
                    ctl.meta_we    = 1'b1;
                    ctl.meta_waddr = split_b;
                    ctl.meta_wdata = '{tag: TAG_FREE, order: jm1};
                    j_next         = jm1;
                    su_next        = split_b;
                    sk_next        = jm1;
                    ret_next       = S_ASPLIT;
                    state_next     = S_PS1;
                end
                else
                begin
                    ctl.meta_we    = 1'b1;
                    ctl.meta_waddr = u_reg;
                    ctl.meta_wdata = '{tag: TAG_USED, order: k_reg};
                    ctl.next_we    = 1'b1;
                    ctl.next_waddr = u_reg;
                    ctl.next_wdata = LINK_NONE;
                    ctl.prev_we    = 1'b1;
                    ctl.prev_waddr = u_reg;
                    ctl.prev_wdata = LINK_NONE;
                    res_next       = {u_reg, {MIN_BLOCK_LOG2{1'b0}}} + ADDR_W'(HEADER_BYTES);
                    st_next        = ST_OK;
                    state_next     = S_AFIN;
                end
            end
            S_AFIN:
            begin
                if (op_reg == OP_REALLOC && addr_reg != '0)
                begin
                    copy_next  = ADDR_W'((21'd1 << old_k_reg) - 21'(HEADER_BYTES));
                    u_next     = old_u_reg;
                    k_next     = old_k_reg;
                    state_next = S_FCHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FCHK:
            begin
                if (k_reg < pool_reg)
                begin
                    ctl.meta_raddr = free_b;
                    b_next         = free_b;
                    state_next     = S_FTEST;
                end
                else
                begin
                    state_next = S_FEND;
                end
            end
            S_FTEST:
            begin
                if (rd.meta.tag == TAG_FREE && rd.meta.order == k_reg)
                begin
                    su_next    = b_reg;
                    sk_next    = k_reg;
                    ret_next   = S_FMRG;
                    state_next = S_RM1;
                end
                else
                begin
                    state_next = S_FEND;
                end
            end
            S_FMRG:
            begin
                ctl.meta_we    = 1'b1;
                ctl.meta_waddr = (b_reg > u_reg) ? b_reg : u_reg;
                ctl.meta_wdata = '{tag: TAG_NONE, order: '0};
                u_next         = (b_reg < u_reg) ? b_reg : u_reg;
                k_next         = k_reg + ORD_W'(1);
                state_next     = S_FCHK;
            end
            S_FEND:
            begin
                ctl.meta_we    = 1'b1;
                ctl.meta_waddr = u_reg;
                ctl.meta_wdata = '{tag: TAG_FREE, order: k_reg};
                su_next        = u_reg;
                sk_next        = k_reg;
                ret_next       = S_DONE;
                state_next     = S_PS1;
            end
            S_RM1:
            begin
                state_next = S_RM2;
            end
            S_RM2:
            begin
                if (!rd.prev[UNIT_W])
                begin
                    ctl.next_we    = 1'b1;
                    ctl.next_waddr = rd.prev[UNIT_W-1:0];
                    ctl.next_wdata = rd.next;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = rd.next;
                end
                if (!rd.next[UNIT_W])
                begin
                    ctl.prev_we    = 1'b1;
                    ctl.prev_waddr = rd.next[UNIT_W-1:0];
                    ctl.prev_wdata = rd.prev;
                end
                state_next = ret_reg;
            end
            S_PS1:
            begin
                ctl.next_we    = 1'b1;
                ctl.next_waddr = su_reg;
                ctl.next_wdata = head_k;
                ctl.prev_we    = 1'b1;
                ctl.prev_waddr = su_reg;
                ctl.prev_wdata = LINK_NONE;
                head_we        = 1'b1;
                head_wdata     = LINK_W'(su_reg);
                h_next         = head_k;
                state_next     = S_PS2;
            end
            S_PS2:
            begin
                if (!h_reg[UNIT_W])
                begin
                    ctl.prev_we    = 1'b1;
                    ctl.prev_waddr = h_reg[UNIT_W-1:0];
                    ctl.prev_wdata = LINK_W'(su_reg);
                end
                state_next = ret_reg;
            end
            S_DONE:
            begin
                done_next     = 1'b1;
                status_next   = st_reg;
                address_next  = (st_reg == ST_OK) ? res_reg : '0;
                copy_out_next = (st_reg == ST_OK) ? copy_reg : '0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_data < 5'(MIN_BLOCK_LOG2 + 1))
            begin
                pool_next = ORD_W'(MIN_BLOCK_LOG2 + 1);
            end
            else if (cfg_data > 5'(MAX_POOL_LOG2))
            begin
                pool_next = ORD_W'(MAX_POOL_LOG2);
            end
            else
            begin
                pool_next = cfg_data;
            end
            clr_next   = '0;
            state_next = S_CLR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_IDLE;
            pool_reg  <= ORD_W'(MAX_POOL_LOG2);
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            pool_reg  <= pool_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= LINK_NONE;
            end
        end
        else if (fmt)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= (ORD_W'(i) == pool_reg) ? '0 : LINK_NONE;
            end
        end
        else if (head_we)
        begin
            head_reg[head_idx] <= head_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        need_reg     <= need_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        u_reg        <= u_next;
        b_reg        <= b_next;
        su_reg       <= su_next;
        old_u_reg    <= old_u_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        sk_reg       <= sk_next;
        old_k_reg    <= old_k_next;
        h_reg        <= h_next;
        st_reg       <= st_next;
        res_reg      <= res_next;
        copy_reg     <= copy_next;
        address_reg  <= address_next;
        status_reg   <= status_next;
        copy_out_reg <= copy_out_next;
    end

endmodule

// ===== sim/buddy_block_allocator_tb.sv =====
`timescale 1ns / 1ps

module buddy_block_allocator_tb;
    import bba_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [1:0]        status;
        logic [ADDR_W-1:0] copy_bytes;
    } alloc_reply_t;

    class alloc_scoreboard;
        alloc_reply_t pending[$];
        int errors;
        int pool;
        tag_t  tag[UNIT_COUNT];
        int    ord[UNIT_COUNT];
        int    nxt[UNIT_COUNT];
        int    prv[UNIT_COUNT];
        int    head[LEVELS];
        int    live[$];

        function void format(int p);
            pool = (p < MIN_BLOCK_LOG2 + 1) ? MIN_BLOCK_LOG2 + 1 :
                   (p > MAX_POOL_LOG2) ? MAX_POOL_LOG2 : p;
            for (int i = 0; i < UNIT_COUNT; i++)
            begin
                tag[i] = TAG_NONE;
                ord[i] = 0;
                nxt[i] = UNIT_COUNT;
                prv[i] = UNIT_COUNT;
            end
            for (int k = 0; k < LEVELS; k++)
                head[k] = UNIT_COUNT;
            tag[0] = TAG_FREE;
            ord[0] = pool;
            push(0, pool);
            live.delete();
        endfunction

        function void push(int u, int k);
            nxt[u] = head[k];
            prv[u] = UNIT_COUNT;
            if (head[k] < UNIT_COUNT)
                prv[head[k]] = u;
            head[k] = u;
        endfunction

        function void unlink(int u, int k);
            if (prv[u] < UNIT_COUNT)
                nxt[prv[u]] = nxt[u];
            else
                head[k] = nxt[u];
            if (nxt[u] < UNIT_COUNT)
                prv[nxt[u]] = prv[u];
        endfunction

        function int lookup(longint a);
            longint off;
            if (a < HEADER_BYTES)
                return UNIT_COUNT;
            off = a - HEADER_BYTES;
            if (off % (1 << MIN_BLOCK_LOG2) != 0)
                return UNIT_COUNT;
            if ((off >> MIN_BLOCK_LOG2) >= (1 << (pool - MIN_BLOCK_LOG2)))
                return UNIT_COUNT;
            if (tag[off >> MIN_BLOCK_LOG2] != TAG_USED)
                return UNIT_COUNT;
            return int'(off >> MIN_BLOCK_LOG2);
        endfunction

        function logic [1:0] grab(longint size, output longint a);
            longint need;
            int k, j, u, b;
            need = size + HEADER_BYTES;
            k = MIN_BLOCK_LOG2;
            a = 0;
            if (size == 0)
                return ST_NULL;
            while (k < 63 && (longint'(1) << k) < need)
                k++;
            if (k > pool)
                return ST_OOM;
            j = k;
            while (j <= pool && head[j] >= UNIT_COUNT)
                j++;
            if (j > pool)
                return ST_OOM;
            u = head[j];
            unlink(u, j);
            while (j > k)
            begin
                j--;
                b = u + (1 << (j - MIN_BLOCK_LOG2));
                tag[b] = TAG_FREE;
                ord[b] = j;
                push(b, j);
            end
            tag[u] = TAG_USED;
            ord[u] = k;
            nxt[u] = UNIT_COUNT;
            prv[u] = UNIT_COUNT;
            a = (longint'(u) << MIN_BLOCK_LOG2) + HEADER_BYTES;
            live.push_back(int'(a));
            return ST_OK;
        endfunction

        function void release_block(int u);
            int k, b, hi;
            k = ord[u];
            for (int i = 0; i < live.size(); i++)
                if (live[i] == (u << MIN_BLOCK_LOG2) + HEADER_BYTES)
                begin
                    live.delete(i);
                    break;
                end
            while (k < pool)
            begin
                b = u ^ (1 << (k - MIN_BLOCK_LOG2));
                if (tag[b] != TAG_FREE || ord[b] != k)
                    break;
                unlink(b, k);
                hi = (b > u) ? b : u;
                if (b < u)
                    u = b;
                tag[hi] = TAG_NONE;
                ord[hi] = 0;
                k++;
            end
            tag[u] = TAG_FREE;
            ord[u] = k;
            push(u, k);
        endfunction

        function void note_item(logic [1:0] o, logic [31:0] sz, logic [ADDR_W-1:0] ba);
            alloc_reply_t r;
            longint a, old;
            int u;
            logic [1:0] st;
            a = 0;
            old = 0;
            st = ST_NULL;
            if (o == OP_ALLOC)
                st = grab(sz, a);
            else if (o == OP_FREE)
            begin
                u = lookup(ba);
                if (ba != 0 && u < UNIT_COUNT)
                begin
                    release_block(u);
                    st = ST_OK;
                end
            end
            else if (o == OP_REALLOC)
            begin
                if (ba == 0)
                    st = grab(sz, a);
                else
                begin
                    u = lookup(ba);
                    if (u < UNIT_COUNT)
                    begin
                        if (sz == 0)
                            release_block(u);
                        else if (longint'(sz) + HEADER_BYTES <= (longint'(1) << ord[u]))
                        begin
                            a = ba;
                            st = ST_OK;
                        end
                        else
                        begin
                            st = grab(sz, a);
                            if (st == ST_OK)
                            begin
                                old = (longint'(1) << ord[u]) - HEADER_BYTES;
                                release_block(u);
                            end
                        end
                    end
                end
            end
            if (st != ST_OK)
            begin
                a = 0;
                old = 0;
            end
            r.address = a[ADDR_W-1:0];
            r.status = st;
            r.copy_bytes = old[ADDR_W-1:0];
            pending.push_back(r);
        endfunction

        function void check_reply(logic [ADDR_W-1:0] a, logic [1:0] s, logic [ADDR_W-1:0] c);
            alloc_reply_t e;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result address %h status %0d copy %h", $time, a, s, c);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.address !== a)
            begin
                $display("%0t address expected %h actual %h", $time, e.address, a);
                errors++;
            end
            if (e.status !== s)
            begin
                $display("%0t status expected %0d actual %0d", $time, e.status, s);
                errors++;
            end
            if (e.copy_bytes !== c)
            begin
                $display("%0t copy_bytes expected %h actual %h", $time, e.copy_bytes, c);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              start = 0;
    logic              busy;
    logic [1:0]        op = 0;
    logic [SIZE_W-1:0] request_size = 0;
    logic [ADDR_W-1:0] block_address = 0;
    logic              done;
    logic [ADDR_W-1:0] address;
    logic [1:0]        status;
    logic [ADDR_W-1:0] copy_bytes;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [4:0]        cfg_data = 0;

    alloc_scoreboard sb;
    bit quiet;

    buddy_block_allocator dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
        if (rst_n && done)
            sb.check_reply(address, status, copy_bytes);

    task automatic send_item(logic [1:0] o, logic [31:0] sz, logic [ADDR_W-1:0] ba);
        int gap;
        if (!quiet && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(14, 1);
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        op <= o;
        request_size <= sz;
        block_address <= ba;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(o, sz, ba);
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_pool(logic [4:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.format(v);
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 0;
            2: return $urandom_range(1 << 14);
            default: return $urandom_range(400, 1);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        if (sb.live.size() != 0 && $urandom_range(9) < 7)
            return ADDR_W'(sb.live[$urandom_range(sb.live.size() - 1)]);
        if ($urandom_range(3) == 0)
            return 0;
        return ADDR_W'($urandom());
    endfunction

    task automatic random_phase(int n);
        logic [1:0] o;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0: o = OP_NONE;
                1, 2, 3, 4, 5, 6, 7: o = OP_ALLOC;
                8, 9, 10, 11, 12, 13: o = OP_FREE;
                default: o = OP_REALLOC;
            endcase
            send_item(o, pick_size(), pick_addr());
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        sb = new();
        sb.format(20);
        repeat (8) @(posedge clk);
        rst_n <= 1;
        send_item(OP_ALLOC, 0, 0);
        send_item(OP_ALLOC, 32'hFFFF_FFFF, 0);
        send_item(OP_ALLOC, 1, 0);
        send_item(OP_ALLOC, 32, 0);
        send_item(OP_ALLOC, 33, 0);
        send_item(OP_ALLOC, (1 << 19) - 32, 0);
        send_item(OP_ALLOC, (1 << 19), 0);
        send_item(OP_FREE, 0, 0);
        send_item(OP_FREE, 0, 20'hFFFFF);
        send_item(OP_FREE, 0, 20'd16);
        send_item(OP_FREE, 0, 20'd33);
        send_item(OP_FREE, 0, 20'd96);
        send_item(OP_REALLOC, 20, 20'd32);
        send_item(OP_REALLOC, 200, 20'd32);
        send_item(OP_REALLOC, 32'hFFFF_FFFF, 20'd96);
        send_item(OP_REALLOC, 0, 20'd96);
        send_item(OP_REALLOC, 10, 0);
        send_item(OP_NONE, 32'hFFFF_FFFF, 20'hFFFFF);
        send_item(OP_FREE, 0, 20'd32);
        write_pool(5'd0);
        send_item(OP_ALLOC, 96, 0);
        send_item(OP_ALLOC, 32, 0);
        send_item(OP_ALLOC, 32, 0);
        send_item(OP_REALLOC, 32, 20'd32);
        random_phase(120);
        drain();
        write_pool(5'd31);
        random_phase(100);
        write_pool(5'd9);
        random_phase(100);
        write_pool(5'd12);
        quiet = 1;
        random_phase(80);
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bba_store.sv
rtl/buddy_block_allocator.sv
sim/buddy_block_allocator_tb.sv
